// File: hw/rtl/tpc_pkg.sv
// shared constants and types for the touch calibration and mapping block
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int RAW_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int SIZE_BITS = 11;
  localparam int SCALE_W   = SIZE_BITS + FRAC_BITS;
  localparam int PROD_W    = RAW_BITS + SCALE_W;
  localparam int CNT_W     = $clog2(SCALE_W);

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_CAL     = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SETTLE = 2'd2;
  localparam logic [1:0] CFG_MARGIN = 2'd3;

  // calibration phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(320);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(240);
  localparam logic [15:0]          SETTLE_RST = 16'd1000;
  localparam logic [7:0]           MARGIN_RST = 8'd10;

  // request to the shared divide / multiply unit
  typedef struct packed {
    logic                mul;
    logic [SCALE_W-1:0]  opa;
    logic [RAW_BITS-1:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: hw/rtl/tpc_iter_unit.sv
// shared bit-serial unit: restoring divide or shift-add multiply, one bit per cycle
`timescale 1ns / 1ps

module tpc_iter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  tpc_pkg::unit_req_t           req_i,
  output tpc_pkg::unit_stat_t          stat_o,
  output logic [tpc_pkg::PROD_W-1:0]   result_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [tpc_pkg::CNT_W-1:0]     cnt_q;
  logic                          mul_q;
  logic [tpc_pkg::RAW_BITS-1:0]  rem_q;
  logic [tpc_pkg::SCALE_W-1:0]   sh_q;
  logic [tpc_pkg::PROD_W-1:0]    acc_q;
  logic [tpc_pkg::RAW_BITS-1:0]  mb_q;
  logic [tpc_pkg::SCALE_W-1:0]   mc_q;

  logic [tpc_pkg::RAW_BITS:0]    trial;
  logic [tpc_pkg::RAW_BITS:0]    dvs;
  logic [tpc_pkg::RAW_BITS:0]    diff;
  logic                          ge;
  logic [tpc_pkg::PROD_W-1:0]    addend;
  logic [tpc_pkg::PROD_W-1:0]    acc_nx;

  always_comb begin
    // divide step: bring down the next dividend bit, subtract when it fits
    trial  = {rem_q, sh_q[tpc_pkg::SCALE_W-1]};
    dvs    = {1'b0, mc_q[tpc_pkg::RAW_BITS-1:0]};
    ge     = (trial >= dvs);
    diff   = trial - dvs;
    // multiply step: multiplier bits msb first
    addend = mb_q[tpc_pkg::RAW_BITS-1] ?
             {{tpc_pkg::RAW_BITS{1'b0}}, mc_q} : '0;
    acc_nx = {acc_q[tpc_pkg::PROD_W-2:0], 1'b0} + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.mul ? tpc_pkg::CNT_W'(tpc_pkg::RAW_BITS - 1)
                            : tpc_pkg::CNT_W'(tpc_pkg::SCALE_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // a zero divisor always fits, so the quotient comes out all ones
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mul_q <= req_i.mul;
      mc_q  <= req_i.mul ? req_i.opa : {{tpc_pkg::SIZE_BITS{1'b0}}, req_i.opb};
      sh_q  <= req_i.opa;
      mb_q  <= req_i.opb;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      if (mul_q) begin
        acc_q <= acc_nx;
        mb_q  <= {mb_q[tpc_pkg::RAW_BITS-2:0], 1'b0};
      end else begin
        rem_q <= ge ? diff[tpc_pkg::RAW_BITS-1:0] : trial[tpc_pkg::RAW_BITS-1:0];
        sh_q  <= {sh_q[tpc_pkg::SCALE_W-2:0], ge};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = mul_q ? acc_q : {{tpc_pkg::RAW_BITS{1'b0}}, sh_q};

endmodule

// File: hw/rtl/touch_two_point_calibrate_map_top.sv
// two-point touch calibration and raw-to-screen mapping, top level
// restart, target-only and status transactions go straight to S_FIN and the output register;
// convert first runs two 12-step multiplies and the finishing calibration sample two 27-step
// divides, all through the shared bit-serial unit
// flow: one transaction at a time; input stalls until its result enters the output register
// reset: async active low, restores register defaults, phase 0, unit scales and zero offsets
`timescale 1ns / 1ps

module touch_two_point_calibrate_map_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic                          touched_i,
  input  logic [tpc_pkg::RAW_BITS-1:0]  raw_x_i,
  input  logic [tpc_pkg::RAW_BITS-1:0]  raw_y_i,
  input  logic [31:0]                   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          target_valid_o,
  output logic [10:0]                   target_x_o,
  output logic [10:0]                   target_y_o,
  output logic                          cal_done_o,
  output logic                          point_valid_o,
  output logic signed [15:0]            screen_x_o,
  output logic signed [15:0]            screen_y_o
);

  localparam int RB  = tpc_pkg::RAW_BITS;
  localparam int FB  = tpc_pkg::FRAC_BITS;
  localparam int SW  = tpc_pkg::SCALE_W;
  localparam int PW  = tpc_pkg::PROD_W;
  localparam int YW  = PW + 2;
  localparam int TW  = YW - FB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DXGO = 4'd1;
  localparam logic [3:0] S_DXW  = 4'd2;
  localparam logic [3:0] S_DYGO = 4'd3;
  localparam logic [3:0] S_DYW  = 4'd4;
  localparam logic [3:0] S_MXGO = 4'd5;
  localparam logic [3:0] S_MXW  = 4'd6;
  localparam logic [3:0] S_MYGO = 4'd7;
  localparam logic [3:0] S_MYW  = 4'd8;
  localparam logic [3:0] S_YADD = 4'd9;
  localparam logic [3:0] S_YSAT = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  // configuration
  logic [10:0]   width_q, height_q;
  logic [15:0]   settle_q;
  logic [7:0]    margin_q;

  // calibration state
  logic [1:0]    phase_q;
  logic [RB-1:0] first_x_q, first_y_q;
  logic [31:0]   phase_time_q;
  logic [SW-1:0] scale_x_q, scale_y_q;
  logic [RB-1:0] off_x_q, off_y_q;

  // sequencer and work registers
  logic [3:0]    state_q, state_d;
  logic [RB-1:0] dabs_x_q, dabs_y_q;
  logic [RB-1:0] mag_x_q, mag_y_q;
  logic          neg_x_q, neg_y_q;
  logic [PW-1:0] prod_q;
  logic [YW-1:0] py_q;

  // pending result
  logic          res_tv_q, res_pv_q;
  logic [10:0]   res_tx_q, res_ty_q;
  logic [15:0]   res_sx_q, res_sy_q;

  // output register
  logic          out_valid_q;

  logic                 in_acc;
  logic                 out_free;
  logic [RB:0]          dif_x, dif_y, cvt_x, cvt_y;
  logic [RB-1:0]        abs_x, abs_y, cmag_x, cmag_y;
  logic [31:0]          elapsed;
  logic                 late;
  logic [10:0]          tx_far, ty_far;
  logic                 unit_start;
  tpc_pkg::unit_req_t   unit_req;
  tpc_pkg::unit_stat_t  unit_stat;
  logic [PW-1:0]        unit_res;
  logic [PW-FB-1:0]     hi_x;
  logic [15:0]          neg_hi_x;
  logic [15:0]          sat_x;
  logic [YW-1:0]        h_ext, p_ext, py_d, y_adj;
  logic [TW-1:0]        t_y;
  logic [15:0]          sat_y;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    dif_x   = {1'b0, first_x_q} - {1'b0, raw_x_i};
    dif_y   = {1'b0, first_y_q} - {1'b0, raw_y_i};
    abs_x   = dif_x[RB] ? RB'(-dif_x) : dif_x[RB-1:0];
    abs_y   = dif_y[RB] ? RB'(-dif_y) : dif_y[RB-1:0];
    cvt_x   = {1'b0, raw_y_i} - {1'b0, off_x_q};
    cvt_y   = {1'b0, raw_x_i} - {1'b0, off_y_q};
    cmag_x  = cvt_x[RB] ? RB'(-cvt_x) : cvt_x[RB-1:0];
    cmag_y  = cvt_y[RB] ? RB'(-cvt_y) : cvt_y[RB-1:0];
    elapsed = now_ms_i - phase_time_q;
    late    = elapsed > {16'd0, settle_q};
    // far corner target, clamped at zero
    tx_far  = (width_q > {3'd0, margin_q}) ? width_q - {3'd0, margin_q} : 11'd0;
    ty_far  = (height_q > {3'd0, margin_q}) ? height_q - {3'd0, margin_q} : 11'd0;
  end

  always_comb begin
    unit_start   = 1'b0;
    unit_req.mul = 1'b0;
    unit_req.opa = {width_q, {FB{1'b0}}};
    unit_req.opb = dabs_y_q;
    case (state_q)
      S_DXGO: begin
        unit_start = 1'b1;
      end
      S_DYGO: begin
        unit_start   = 1'b1;
        unit_req.opa = {height_q, {FB{1'b0}}};
        unit_req.opb = dabs_x_q;
      end
      S_MXGO: begin
        unit_start   = 1'b1;
        unit_req.mul = 1'b1;
        unit_req.opa = scale_x_q;
        unit_req.opb = mag_x_q;
      end
      S_MYGO: begin
        unit_start   = 1'b1;
        unit_req.mul = 1'b1;
        unit_req.opa = scale_y_q;
        unit_req.opb = mag_y_q;
      end
      default: begin
        unit_start = 1'b0;
      end
    endcase
  end

  tpc_iter_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .req_i    (unit_req),
    .stat_o   (unit_stat),
    .result_o (unit_res)
  );

  // screen x: truncate the magnitude, then restore the sign and saturate
  always_comb begin
    hi_x     = unit_res[PW-1:FB];
    neg_hi_x = ~hi_x[15:0] + 16'd1;
    if (!neg_x_q) begin
      sat_x = (hi_x > (PW-FB)'(32767)) ? 16'h7FFF : hi_x[15:0];
    end else begin
      sat_x = (hi_x > (PW-FB)'(32768)) ? 16'h8000 : neg_hi_x;
    end
  end

  // screen y: height minus signed product, truncated toward zero, then saturated
  always_comb begin
    h_ext = YW'({height_q, {FB{1'b0}}});
    p_ext = YW'(prod_q);
    py_d  = neg_y_q ? h_ext + p_ext : h_ext - p_ext;
    y_adj = py_q + (py_q[YW-1] ? YW'({FB{1'b1}}) : YW'(0));
    t_y   = y_adj[YW-1:FB];
    if (!t_y[TW-1] && (t_y[TW-2:15] != '0)) begin
      sat_y = 16'h7FFF;
    end else if (t_y[TW-1] && (t_y[TW-2:15] != '1)) begin
      sat_y = 16'h8000;
    end else begin
      sat_y = t_y[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((op_i == tpc_pkg::OP_CAL) && (phase_q == tpc_pkg::PH_SECOND) && touched_i &&
              late) begin
            state_d = S_DXGO;
          end else if (op_i == tpc_pkg::OP_CONVERT) begin
            state_d = S_MXGO;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DXGO: state_d = S_DXW;
      S_DXW:  if (unit_stat.done) state_d = S_DYGO;
      S_DYGO: state_d = S_DYW;
      S_DYW:  if (unit_stat.done) state_d = S_FIN;
      S_MXGO: state_d = S_MXW;
      S_MXW:  if (unit_stat.done) state_d = S_MYGO;
      S_MYGO: state_d = S_MYW;
      S_MYW:  if (unit_stat.done) state_d = S_YADD;
      S_YADD: state_d = S_YSAT;
      S_YSAT: state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      width_q      <= tpc_pkg::WIDTH_RST;
      height_q     <= tpc_pkg::HEIGHT_RST;
      settle_q     <= tpc_pkg::SETTLE_RST;
      margin_q     <= tpc_pkg::MARGIN_RST;
      phase_q      <= tpc_pkg::PH_FIRST;
      first_x_q    <= '0;
      first_y_q    <= '0;
      phase_time_q <= '0;
      scale_x_q    <= SW'(1) << FB;
      scale_y_q    <= SW'(1) << FB;
      off_x_q      <= '0;
      off_y_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tpc_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
          tpc_pkg::CFG_HEIGHT: height_q <= cfg_data_i[10:0];
          tpc_pkg::CFG_SETTLE: settle_q <= cfg_data_i;
          tpc_pkg::CFG_MARGIN: margin_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (op_i == tpc_pkg::OP_RESTART) begin
          phase_q <= tpc_pkg::PH_FIRST;
        end else if ((op_i == tpc_pkg::OP_CAL) && touched_i) begin
          if (phase_q == tpc_pkg::PH_FIRST) begin
            first_x_q    <= raw_x_i;
            first_y_q    <= raw_y_i;
            phase_time_q <= now_ms_i;
            phase_q      <= tpc_pkg::PH_SECOND;
          end else if ((phase_q == tpc_pkg::PH_SECOND) && late) begin
            off_x_q      <= (first_y_q < raw_y_i) ? first_y_q : raw_y_i;
            off_y_q      <= (first_x_q < raw_x_i) ? first_x_q : raw_x_i;
            phase_time_q <= now_ms_i;
            phase_q      <= tpc_pkg::PH_DONE;
          end
        end
      end
      if ((state_q == S_DXW) && unit_stat.done) scale_x_q <= unit_res[SW-1:0];
      if ((state_q == S_DYW) && unit_stat.done) scale_y_q <= unit_res[SW-1:0];
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_tv_q <= 1'b0;
      res_tx_q <= '0;
      res_ty_q <= '0;
      res_pv_q <= 1'b0;
      res_sx_q <= '0;
      res_sy_q <= '0;
      dabs_x_q <= abs_x;
      dabs_y_q <= abs_y;
      mag_x_q  <= cmag_x;
      mag_y_q  <= cmag_y;
      neg_x_q  <= cvt_x[RB];
      neg_y_q  <= cvt_y[RB];
      if (op_i == tpc_pkg::OP_CAL) begin
        if (phase_q == tpc_pkg::PH_FIRST) begin
          res_tv_q <= 1'b1;
          res_tx_q <= {3'd0, margin_q};
          res_ty_q <= {3'd0, margin_q};
        end else if (phase_q == tpc_pkg::PH_SECOND) begin
          res_tv_q <= 1'b1;
          res_tx_q <= tx_far;
          res_ty_q <= ty_far;
        end
      end else if (op_i == tpc_pkg::OP_CONVERT) begin
        res_pv_q <= 1'b1;
      end
    end
    if ((state_q == S_MXW) && unit_stat.done) res_sx_q <= sat_x;
    if ((state_q == S_MYW) && unit_stat.done) prod_q <= unit_res;
    if (state_q == S_YADD) py_q <= py_d;
    if (state_q == S_YSAT) res_sy_q <= sat_y;
    if ((state_q == S_FIN) && out_free) begin
      target_valid_o <= res_tv_q;
      target_x_o     <= res_tx_q;
      target_y_o     <= res_ty_q;
      cal_done_o     <= phase_q[1];
      point_valid_o  <= res_pv_q;
      screen_x_o     <= res_sx_q;
      screen_y_o     <= res_sy_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // the shared unit is only launched when idle
  a_unit_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |-> !unit_stat.busy)
    else $error("shared unit started while busy");

  // a finished transaction lands in the output register and the sequencer frees up
  a_fin_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_free |=> out_valid_o && (state_q == S_IDLE))
    else $error("result not handed to output register");

  // a result never carries both a target and a converted point
  a_excl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(target_valid_o && point_valid_o))
    else $error("target and point reported together");

  // the calibration phase never reaches the unused code
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> phase_q != 2'd3)
    else $error("calibration phase out of range");

endmodule
